// File: sv/tlbm_pkg.sv
// Package for the TLB and demand-paging translation block.
// Holds shared widths, defaults, the channel payload types and the controller/datapath
// command and status types.
`timescale 1ns / 1ps
package tlbm_pkg;
    localparam int unsigned PageCountDef  = 256;
    localparam int unsigned OffsetBits    = 8;
    localparam int unsigned TlbDepthDef   = 16;
    localparam int unsigned FrameCountDef = 128;
    localparam int unsigned VaW           = 16;
    localparam int unsigned PaW           = 15;
    localparam int unsigned PageW         = 8;
    localparam int unsigned StampW        = 32;

    typedef struct packed {
        logic [VaW-1:0] virtual_address;
    } t_req;

    typedef struct packed {
        logic [PaW-1:0]   physical_address;
        logic             tlb_hit;
        logic             page_fault;
        logic             evicted_valid;
        logic [PageW-1:0] evicted_page;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic tlb_scan;
        logic pt_read;
        logic resolve;
        logic victim_scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic tlb_done;
        logic victim_done;
        logic need_victim;
    } t_status;
endpackage

// File: sv/tlbm_if.sv
// Valid/ready channel interface carrying one payload beat.
// Depends on nothing; the payload type is a parameter.
`timescale 1ns / 1ps
interface tlbm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/tlbm_ctrl.sv
// Controller state machine for the translation block.
// Depends on tlbm_pkg for the command and status structs.
`timescale 1ns / 1ps
module tlbm_ctrl
    import tlbm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_TLB, S_PT, S_RES, S_VIC, S_COMMIT, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd             = '0;
        o_cmd.load        = (r_state == S_IDLE) && i_in_valid;
        o_cmd.tlb_scan    = (r_state == S_TLB);
        o_cmd.pt_read     = (r_state == S_PT);
        o_cmd.resolve     = (r_state == S_RES);
        o_cmd.victim_scan = (r_state == S_VIC);
        o_cmd.commit      = (r_state == S_COMMIT);
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PT;
                end
            end
            S_PT: begin
                n_state = S_TLB;
            end
            S_TLB: begin
                if (i_status.tlb_done) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                n_state = i_status.need_victim ? S_VIC : S_COMMIT;
            end
            S_VIC: begin
                if (i_status.victim_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                n_state     = S_OUT;
                n_out_valid = 1'b1;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// File: sv/tlbm_dp.sv
// Datapath: TLB registers, page table and frame memories, scan counters and result register.
// Depends on tlbm_pkg for widths and the command and status structs.
`timescale 1ns / 1ps
module tlbm_dp
    import tlbm_pkg::*;
#(
    parameter int unsigned PAGE_COUNT  = PageCountDef,
    parameter int unsigned TLB_DEPTH   = TlbDepthDef,
    parameter int unsigned FRAME_COUNT = FrameCountDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [VaW-1:0]        i_va,
    output logic [PaW-1:0]        o_pa,
    output logic                  o_hit,
    output logic                  o_fault,
    output logic                  o_evicted_valid,
    output logic [PageW-1:0]      o_evicted_page
);
    localparam int unsigned PgW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int unsigned FrW  = $clog2(FRAME_COUNT);
    localparam int unsigned FrCW = $clog2(FRAME_COUNT + 1);
    localparam int unsigned TW   = $clog2(TLB_DEPTH);
    localparam int unsigned TCW  = $clog2(TLB_DEPTH + 1);
    localparam int unsigned RemW = PageW + 5;

    logic [PgW-1:0]    r_tlb_page [TLB_DEPTH];
    logic [FrW-1:0]    r_tlb_frame [TLB_DEPTH];
    logic [StampW-1:0] r_tlb_stamp [TLB_DEPTH];
    logic [TCW-1:0]    r_tlb_fill;
    logic [PAGE_COUNT-1:0] r_page_valid;
    logic [FrW-1:0]    r_page_frame_mem [PAGE_COUNT];
    logic [PgW-1:0]    r_frame_owner_mem [FRAME_COUNT];
    logic [StampW-1:0] r_last_use_mem [FRAME_COUNT];
    logic [FrCW-1:0]   r_next_free;
    logic [StampW-1:0] r_ref;

    logic [PgW-1:0]    r_page;
    logic [OffsetBits-1:0] r_off;
    logic              r_pvalid;
    logic [FrW-1:0]    r_pframe;
    logic [TCW-1:0]    r_ti;
    logic              r_hit;
    logic [TW-1:0]     r_slot;
    logic [TW-1:0]     r_old;
    logic [FrCW-1:0]   r_vi;
    logic [FrW-1:0]    r_best;
    logic [StampW-1:0] r_best_stamp;
    logic              r_rd_pend;
    logic [FrW-1:0]    r_rd_idx;
    logic [StampW-1:0] r_rd_stamp;
    logic [PgW-1:0]    r_owner_rd;
    logic              r_fault;
    logic              r_evict;
    logic [FrW-1:0]    r_frame;

    logic [PgW-1:0] w_page;
    logic [TW-1:0]  w_ti;
    logic           w_match;
    logic           w_need_victim;
    logic [FrW-1:0] w_vi;
    logic [PAGE_COUNT-1:0] w_clr_mask;
    logic [PAGE_COUNT-1:0] w_set_mask;

    function automatic logic [PgW-1:0] page_mod(logic [PageW-1:0] pg);
        logic [RemW-1:0] rem;
        rem = RemW'(pg);
        for (int k = 3; k >= 0; k--) begin
            if (rem >= RemW'(PAGE_COUNT << k)) begin
                rem = rem - RemW'(PAGE_COUNT << k);
            end
        end
        return rem[PgW-1:0];
    endfunction

    assign w_page = page_mod(i_va[VaW-1:OffsetBits]);

    assign w_ti    = r_ti[TW-1:0];
    assign w_vi    = r_vi[FrW-1:0];
    assign w_match = (r_tlb_page[w_ti] == r_page) && (r_tlb_frame[w_ti] == r_pframe);
    assign w_need_victim = !r_hit && !r_pvalid && (r_next_free == FrCW'(FRAME_COUNT));
    assign w_clr_mask = r_evict ? (PAGE_COUNT'(1) << r_owner_rd) : '0;
    assign w_set_mask = PAGE_COUNT'(1) << r_page;

    assign o_status.tlb_done    = r_hit || (r_ti >= r_tlb_fill) ||
                                  (w_match && r_pvalid);
    assign o_status.victim_done = (r_vi == FrCW'(FRAME_COUNT)) && !r_rd_pend;
    assign o_status.need_victim = w_need_victim;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= w_page;
            r_off  <= i_va[OffsetBits-1:0];
        end
        if (i_cmd.pt_read) begin
            r_pframe <= r_page_frame_mem[r_page];
        end
        if (i_cmd.victim_scan) begin
            if (r_vi != FrCW'(FRAME_COUNT)) begin
                r_rd_stamp <= r_last_use_mem[w_vi];
                r_rd_idx   <= w_vi;
            end
        end
        if (i_cmd.victim_scan && o_status.victim_done) begin
            r_owner_rd <= r_frame_owner_mem[r_best];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_fault) begin
                r_page_frame_mem[r_page] <= r_frame;
                r_frame_owner_mem[r_frame] <= r_page;
            end
            r_last_use_mem[r_frame] <= r_ref;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlb_fill   <= '0;
            r_page_valid <= '0;
            r_next_free  <= '0;
            r_ref        <= '0;
            r_ti         <= '0;
            r_hit        <= 1'b0;
            r_vi         <= '0;
            r_rd_pend    <= 1'b0;
            r_fault      <= 1'b0;
            r_evict      <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ti    <= '0;
                r_hit   <= 1'b0;
                r_fault <= 1'b0;
                r_evict <= 1'b0;
                r_old   <= '0;
            end
            if (i_cmd.pt_read) begin
                r_pvalid <= r_page_valid[r_page];
            end
            if (i_cmd.tlb_scan) begin
                if (!r_hit) begin
                    if (r_ti < r_tlb_fill) begin
                        if (w_match && r_pvalid) begin
                            r_hit  <= 1'b1;
                            r_slot <= w_ti;
                        end else begin
                            if (r_tlb_stamp[w_ti] < r_tlb_stamp[r_old]) begin
                                r_old <= w_ti;
                            end
                            r_ti <= r_ti + 1'b1;
                        end
                    end
                end
            end
            if (i_cmd.resolve) begin
                r_vi         <= '0;
                r_rd_pend    <= 1'b0;
                r_best       <= '0;
                if (r_hit) begin
                    r_frame <= r_tlb_frame[r_slot];
                end else begin
                    if (r_tlb_fill < TCW'(TLB_DEPTH)) begin
                        r_slot     <= r_tlb_fill[TW-1:0];
                        r_tlb_fill <= r_tlb_fill + 1'b1;
                    end else begin
                        r_slot <= r_old;
                    end
                    if (r_pvalid) begin
                        r_frame <= r_pframe;
                    end else begin
                        r_fault <= 1'b1;
                        if (!w_need_victim) begin
                            r_frame     <= r_next_free[FrW-1:0];
                            r_next_free <= r_next_free + 1'b1;
                        end
                    end
                end
            end
            if (i_cmd.victim_scan) begin
                if (r_vi != FrCW'(FRAME_COUNT)) begin
                    r_vi <= r_vi + 1'b1;
                end
                r_rd_pend <= (r_vi != FrCW'(FRAME_COUNT));
                if (r_rd_pend) begin
                    if (r_rd_idx == '0 || r_rd_stamp < r_best_stamp) begin
                        r_best       <= r_rd_idx;
                        r_best_stamp <= r_rd_stamp;
                    end
                end
                if (o_status.victim_done) begin
                    r_frame <= r_best;
                    r_evict <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                if (r_fault) begin
                    r_page_valid <= (r_page_valid & ~w_clr_mask) | w_set_mask;
                end
                if (!r_hit) begin
                    r_tlb_page[r_slot]  <= r_page;
                    r_tlb_frame[r_slot] <= r_frame;
                end
                r_tlb_stamp[r_slot] <= r_ref;
                r_ref <= r_ref + 1'b1;
                o_pa  <= PaW'({r_frame, r_off});
                o_hit <= r_hit;
                o_fault <= r_fault;
                o_evicted_valid <= r_evict;
                o_evicted_page  <= r_evict ? PageW'(r_owner_rd) : '0;
            end
        end
    end
endmodule

// File: sv/tlb_page_table_lru_mmu.sv
// Top level of the TLB and demand-paging translation block.
// Depends on tlbm_pkg, tlbm_if, tlbm_ctrl and tlbm_dp.
//
// Usage: the input channel i_req carries one 16-bit virtual address per beat (page
// in bits 15:8, offset in bits 7:0). The output channel o_rsp returns one beat per
// input with the 15-bit physical address and the hit, fault and eviction flags.
// The block works on one address at a time. After an input beat is accepted it
// reads the page table, examines the filled TLB entries in turn until a hit or the
// last filled entry, then resolves and commits the result. A fault with all frames
// in use adds a victim search over the frame recency memory, one stamp per cycle,
// before the commit. The input is ready again in the cycle after the result beat
// is taken, so no new address is accepted before the last one is through.
// The result waits in the output register until taken; while it waits the
// input is not ready. Synchronous reset empties the TLB, marks every page
// nonresident and restarts frame allocation and the reference counter.
`timescale 1ns / 1ps
module tlb_page_table_lru_mmu
    import tlbm_pkg::*;
#(
    parameter int unsigned PAGE_COUNT  = PageCountDef,
    parameter int unsigned TLB_DEPTH   = TlbDepthDef,
    parameter int unsigned FRAME_COUNT = FrameCountDef
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tlbm_if.sink  i_req,
    tlbm_if.source o_rsp
);
    t_cmd    w_cmd;
    t_status w_status;

    tlbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tlbm_dp #(
        .PAGE_COUNT  (PAGE_COUNT),
        .TLB_DEPTH   (TLB_DEPTH),
        .FRAME_COUNT (FRAME_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_va            (i_req.data.virtual_address),
        .o_pa            (o_rsp.data.physical_address),
        .o_hit           (o_rsp.data.tlb_hit),
        .o_fault         (o_rsp.data.page_fault),
        .o_evicted_valid (o_rsp.data.evicted_valid),
        .o_evicted_page  (o_rsp.data.evicted_page)
    );
endmodule

// File: dv/tb_tlb_page_table_lru_mmu.sv
// Testbench for the TLB and demand-paging translation block.
// Depends on tlbm_pkg, tlbm_if and tlb_page_table_lru_mmu; checks every output beat
// against a predictor of TLB lookup, frame allocation and LRU eviction.
`timescale 1ns / 1ps
module tb_tlb_page_table_lru_mmu
    import tlbm_pkg::*;
();
    localparam int unsigned NumPages  = PageCountDef;
    localparam int unsigned NumFrames = FrameCountDef;
    localparam int unsigned NumTlb    = TlbDepthDef;
    localparam longint CycleLimit = 2000000;

    logic i_clk;
    logic i_rst_n;
    tlbm_if #(.T(t_req)) req_ch ();
    tlbm_if #(.T(t_rsp)) rsp_ch ();

    tlb_page_table_lru_mmu u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    logic [PageW-1:0]  m_tlb_page  [NumTlb];
    logic [6:0]        m_tlb_frame [NumTlb];
    logic [StampW-1:0] m_tlb_stamp [NumTlb];
    int unsigned       m_tlb_fill;
    logic              m_resident  [NumPages];
    logic [6:0]        m_page_frame[NumPages];
    logic [PageW-1:0]  m_owner     [NumFrames];
    logic [StampW-1:0] m_last_use  [NumFrames];
    int unsigned       m_next_free;
    logic [StampW-1:0] m_ref_count;

    t_rsp   expected_xlats[$];
    bit     failed = 0;
    longint cycles = 0;
    bit     stall_enable = 1;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_rsp translate(logic [VaW-1:0] va);
        t_rsp r;
        logic [PageW-1:0] page;
        int unsigned slot;
        int unsigned frame;
        int unsigned best;
        bit hit;
        page = va[15:8];
        hit = 0;
        slot = 0;
        r = '0;
        if (m_resident[page]) begin
            for (int i = 0; i < m_tlb_fill; i++) begin
                if (!hit && m_tlb_page[i] == page && m_tlb_frame[i] == m_page_frame[page]) begin
                    hit = 1;
                    slot = i;
                end
            end
        end
        if (!hit) begin
            if (!m_resident[page]) begin
                r.page_fault = 1;
                if (m_next_free < NumFrames) begin
                    frame = m_next_free;
                    m_next_free++;
                end else begin
                    best = 0;
                    for (int i = 1; i < NumFrames; i++) begin
                        if (m_last_use[i] < m_last_use[best]) best = i;
                    end
                    frame = best;
                    r.evicted_valid = 1;
                    r.evicted_page = m_owner[frame];
                    m_resident[m_owner[frame]] = 0;
                end
                m_resident[page] = 1;
                m_page_frame[page] = frame[6:0];
                m_owner[frame] = page;
            end
            if (m_tlb_fill < NumTlb) begin
                slot = m_tlb_fill;
                m_tlb_fill++;
            end else begin
                best = 0;
                for (int i = 1; i < NumTlb; i++) begin
                    if (m_tlb_stamp[i] < m_tlb_stamp[best]) best = i;
                end
                slot = best;
            end
            m_tlb_page[slot] = page;
            m_tlb_frame[slot] = m_page_frame[page];
        end
        frame = m_tlb_frame[slot];
        m_last_use[frame] = m_ref_count;
        m_tlb_stamp[slot] = m_ref_count;
        m_ref_count++;
        r.tlb_hit = hit;
        r.physical_address = {frame[6:0], va[7:0]};
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp exp_x;
        t_rsp got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (expected_xlats.size() == 0) begin
                $display("%0t: unexpected beat %p", $time, got);
                failed = 1;
            end else begin
                exp_x = expected_xlats.pop_front();
                if (got.physical_address !== exp_x.physical_address ||
                    got.tlb_hit !== exp_x.tlb_hit ||
                    got.page_fault !== exp_x.page_fault ||
                    got.evicted_valid !== exp_x.evicted_valid ||
                    got.evicted_page !== exp_x.evicted_page) begin
                    $display("%0t: expected %p actual %p", $time, exp_x, got);
                    failed = 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        int unsigned gap;
        if (!i_rst_n) begin
            rsp_ch.ready <= 0;
        end else if (rsp_ch.valid && rsp_ch.ready) begin
            gap = stall_enable ? $urandom_range(0, 4) : 0;
            if (gap != 0) begin
                rsp_ch.ready <= 0;
                for (int i = 0; i < gap; i++) @(posedge i_clk);
                rsp_ch.ready <= 1;
            end
        end else begin
            rsp_ch.ready <= 1;
        end
    end

    task automatic send_address(logic [VaW-1:0] va);
        int unsigned gap;
        gap = stall_enable ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            req_ch.valid <= 0;
            for (int i = 0; i < gap; i++) @(posedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.data.virtual_address <= va;
        do @(posedge i_clk); while (!req_ch.ready);
        expected_xlats.push_back(translate(va));
    endtask

    task automatic test_directed();
        send_address(16'h0000);
        send_address(16'h00ff);
        send_address(16'hff00);
        send_address(16'hffff);
        send_address(16'h5aa5);
        send_address(16'ha55a);
        send_address(16'h0012);
        send_address(16'hff34);
    endtask

    task automatic test_tlb_replacement();
        for (int i = 0; i < 20; i++) send_address({8'(i + 16), 8'($urandom)});
        for (int i = 0; i < 20; i++) send_address({8'(i + 16), 8'($urandom)});
    endtask

    // Fill every frame, then fault on new pages so LRU eviction and stale
    // TLB entries of evicted pages are exercised.
    task automatic test_eviction();
        for (int p = 0; p < 160; p++) send_address({8'(p), 8'($urandom)});
        for (int p = 0; p < 40; p++) send_address({8'(p), 8'($urandom)});
    endtask

    task automatic test_random();
        logic [PageW-1:0] hot [8];
        foreach (hot[i]) hot[i] = 8'($urandom);
        for (int n = 0; n < 400; n++) begin
            if (n == 200) stall_enable = 0;
            if (n == 260) stall_enable = 1;
            if ($urandom_range(0, 2) == 0)
                send_address({hot[$urandom_range(0, 7)], 8'($urandom)});
            else
                send_address(16'($urandom));
        end
    endtask

    initial begin
        req_ch.valid = 0;
        req_ch.data = '0;
        i_rst_n = 0;
        foreach (m_resident[i]) m_resident[i] = 0;
        m_tlb_fill = 0;
        m_next_free = 0;
        m_ref_count = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        test_directed();
        test_tlb_replacement();
        test_eviction();
        test_random();
        req_ch.valid <= 0;
        while (expected_xlats.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (!failed) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
